/* rtl/fpa_pkg.sv */
// Package with shared constants, codes, types and functions of the fixed-point ALU.
package fpa_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 8;
   localparam int QUOT_BITS = WORD_BITS + FRAC_BITS;
   localparam int PROD_BITS = 2 * WORD_BITS;

   localparam logic [WORD_BITS-1:0] SAT_MAX = {1'b0, {(WORD_BITS - 1){1'b1}}};
   localparam logic [WORD_BITS-1:0] SAT_MIN = {1'b1, {(WORD_BITS - 1){1'b0}}};
   localparam logic [PROD_BITS:0] ROUND_HALF =
      (PROD_BITS + 1)'(FRAC_BITS > 0 ? (64'd1 << (FRAC_BITS - 1)) : 64'd0);

   typedef enum logic [3:0] {
      OP_ADD = 4'd0,
      OP_SUB = 4'd1,
      OP_MUL = 4'd2,
      OP_DIV = 4'd3,
      OP_GT  = 4'd4,
      OP_LT  = 4'd5,
      OP_GE  = 4'd6,
      OP_LE  = 4'd7,
      OP_EQ  = 4'd8,
      OP_NE  = 4'd9
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_OVF  = 2'd1,
      ST_DIVZ = 2'd2
   } status_type;

   // Control and early results that travel beside the divider data.
   typedef struct packed {
      logic                 valid;
      logic [3:0]           opcode;
      logic                 neg;
      logic [WORD_BITS-1:0] result;
      logic                 cmp;
      logic [1:0]           status;
   } side_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] rem;
      logic [QUOT_BITS-1:0] num;
      logic [WORD_BITS-1:0] den;
   } div_type;

   typedef struct packed {
      logic                 ovf;
      logic [WORD_BITS-1:0] value;
   } sat_type;

   // Applies the sign to a magnitude and saturates when it leaves the word range.
   function automatic sat_type sat_finish(input logic neg, input logic [PROD_BITS-1:0] mag);
      logic [PROD_BITS-1:0] limit;
      sat_type              r;
      limit = neg ? {{WORD_BITS{1'b0}}, SAT_MIN} : {{WORD_BITS{1'b0}}, SAT_MAX};
      if (mag > limit) begin
         r.ovf   = 1'b1;
         r.value = neg ? SAT_MIN : SAT_MAX;
      end else begin
         r.ovf   = 1'b0;
         r.value = neg ? (~mag[WORD_BITS-1:0] + 1'b1) : mag[WORD_BITS-1:0];
      end
      return r;
   endfunction

endpackage

/* rtl/fpa_mul.sv */
// Registered unsigned magnitude multiplier of the fixed-point ALU.
module fpa_mul (
   input  logic                                  clock,
   input  logic                                  enable,
   input  logic [fpa_pkg::WORD_BITS-1:0]         mag_a,
   input  logic [fpa_pkg::WORD_BITS-1:0]         mag_b,
   output logic [fpa_pkg::PROD_BITS-1:0]         product
);

   logic [fpa_pkg::PROD_BITS-1:0] product_ff;
   logic [fpa_pkg::PROD_BITS-1:0] product_in;

   assign product_in = fpa_pkg::PROD_BITS'(mag_a) * fpa_pkg::PROD_BITS'(mag_b);

   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

/* rtl/fpa_div_stage.sv */
// One restoring-division stage that produces one quotient bit per cycle while enabled.
module fpa_div_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  fpa_pkg::side_type  side_i,
   input  fpa_pkg::div_type   div_i,
   output fpa_pkg::side_type  side_o,
   output fpa_pkg::div_type   div_o
);

   fpa_pkg::side_type side_ff;
   fpa_pkg::div_type  div_ff;
   fpa_pkg::div_type  div_in;
   logic [fpa_pkg::WORD_BITS:0] shifted;
   logic [fpa_pkg::WORD_BITS:0] diff;
   logic                        ge;

   always_comb begin
      shifted    = {div_i.rem, div_i.num[fpa_pkg::QUOT_BITS-1]};
      diff       = shifted - {1'b0, div_i.den};
      ge         = shifted >= {1'b0, div_i.den};
      div_in.den = div_i.den;
      div_in.rem = ge ? diff[fpa_pkg::WORD_BITS-1:0] : shifted[fpa_pkg::WORD_BITS-1:0];
      div_in.num = {div_i.num[fpa_pkg::QUOT_BITS-2:0], ge};
   end

   // Only the valid bit is reset; the data fields simply follow it.
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else if (enable) begin
         side_ff.valid <= side_i.valid;
      end
      if (enable) begin
         side_ff.opcode <= side_i.opcode;
         side_ff.neg    <= side_i.neg;
         side_ff.result <= side_i.result;
         side_ff.cmp    <= side_i.cmp;
         side_ff.status <= side_i.status;
         div_ff         <= div_in;
      end
   end

   assign side_o = side_ff;
   assign div_o  = div_ff;

endmodule

/* rtl/fpa_out_stage.sv */
// Final stage: for a divide without divide by zero, rounds and saturates the quotient; holds the result word.
module fpa_out_stage (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           enable,
   input  fpa_pkg::side_type              side_i,
   input  fpa_pkg::div_type               div_i,
   output logic                           valid,
   output logic [fpa_pkg::WORD_BITS-1:0]  result,
   output logic                           cmp,
   output logic [1:0]                     status
);

   logic                           valid_ff;
   logic [fpa_pkg::WORD_BITS-1:0]  result_ff, result_in;
   logic                           cmp_ff;
   logic [1:0]                     status_ff, status_in;
   logic                           round_up;
   logic [fpa_pkg::QUOT_BITS:0]    quot;
   fpa_pkg::sat_type               sat;

   always_comb begin
      // Round to nearest, ties away from zero: bump when twice the remainder reaches the divisor.
      round_up  = {div_i.rem, 1'b0} >= {1'b0, div_i.den};
      quot      = {1'b0, div_i.num} + {{fpa_pkg::QUOT_BITS{1'b0}}, round_up};
      sat       = fpa_pkg::sat_finish(side_i.neg, fpa_pkg::PROD_BITS'(quot));
      result_in = side_i.result;
      status_in = side_i.status;
      if (side_i.opcode == fpa_pkg::OP_DIV && side_i.status != fpa_pkg::ST_DIVZ) begin
         result_in = sat.value;
         status_in = sat.ovf ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= side_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         result_ff <= result_in;
         cmp_ff    <= side_i.cmp;
         status_ff <= status_in;
      end
   end

   assign valid  = valid_ff;
   assign result = result_ff;
   assign cmp    = cmp_ff;
   assign status = status_ff;

endmodule

/* rtl/fixed_point_alu_core.sv */
// Top level of the pipelined Q24.8 fixed-point ALU.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+--------------------------------------------
//  req      | in        | req_valid / req_ready | req_opcode, req_operand_a, req_operand_b
//  rsp      | out       | rsp_valid / rsp_ready | rsp_result_value, rsp_compare_true, rsp_status
//
// One word is accepted every cycle unless the output word is held.
// The pipeline consists of the 40-stage restoring divider, one quotient bit per stage,
// plus the operand stage, the multiplier stage, the product rounding stage and the
// output register. All opcodes take the same path, so words leave in order.
// Reset (synchronous) clears only the stage valid bits. When the output word is held,
// the whole pipeline freezes and req_ready drops; otherwise every stage advances each
// cycle and empty slots travel along as bubbles.
module fixed_point_alu_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [3:0]                            req_opcode,
   input  logic signed [fpa_pkg::WORD_BITS-1:0]  req_operand_a,
   input  logic signed [fpa_pkg::WORD_BITS-1:0]  req_operand_b,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [fpa_pkg::WORD_BITS-1:0]  rsp_result_value,
   output logic                                  rsp_compare_true,
   output logic [1:0]                            rsp_status
);

   localparam int WB = fpa_pkg::WORD_BITS;
   localparam int QB = fpa_pkg::QUOT_BITS;

   // The pipeline moves whenever the output register is empty or being taken.
   logic advance;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // ---------------- Operand stage ----------------
   // Magnitudes and the result sign are prepared here; add, subtract and the
   // comparisons finish in this stage and simply ride along afterwards.
   fpa_pkg::side_type sa_ff, sa_in;
   logic [WB-1:0]     mag_a_ff, mag_a_in, mag_b_ff, mag_b_in;
   logic [WB:0]       sum;
   logic              a_lt_b;
   fpa_pkg::op_type   op;

   always_comb begin
      op       = fpa_pkg::op_type'(req_opcode);
      mag_a_in = req_operand_a[WB-1] ? (~req_operand_a + 1'b1) : req_operand_a;
      mag_b_in = req_operand_b[WB-1] ? (~req_operand_b + 1'b1) : req_operand_b;
      a_lt_b   = req_operand_a < req_operand_b;
      if (op == fpa_pkg::OP_SUB) begin
         sum = {req_operand_a[WB-1], req_operand_a} - {req_operand_b[WB-1], req_operand_b};
      end else begin
         sum = {req_operand_a[WB-1], req_operand_a} + {req_operand_b[WB-1], req_operand_b};
      end
      sa_in.valid  = req_valid;
      sa_in.opcode = req_opcode;
      sa_in.neg    = req_operand_a[WB-1] ^ req_operand_b[WB-1];
      sa_in.result = '0;
      sa_in.cmp    = 1'b0;
      sa_in.status = fpa_pkg::ST_OK;
      case (op)
         fpa_pkg::OP_ADD, fpa_pkg::OP_SUB: begin
            // The 33-bit sum is exact; its top two bits disagree only on overflow.
            if (sum[WB] != sum[WB-1]) begin
               sa_in.result = sum[WB] ? fpa_pkg::SAT_MIN : fpa_pkg::SAT_MAX;
               sa_in.status = fpa_pkg::ST_OVF;
            end else begin
               sa_in.result = sum[WB-1:0];
            end
         end
         fpa_pkg::OP_DIV: begin
            if (req_operand_b == '0) begin
               sa_in.status = fpa_pkg::ST_DIVZ;
            end
         end
         fpa_pkg::OP_GT: sa_in.cmp = !a_lt_b && (req_operand_a != req_operand_b);
         fpa_pkg::OP_LT: sa_in.cmp = a_lt_b;
         fpa_pkg::OP_GE: sa_in.cmp = !a_lt_b;
         fpa_pkg::OP_LE: sa_in.cmp = a_lt_b || (req_operand_a == req_operand_b);
         fpa_pkg::OP_EQ: sa_in.cmp = req_operand_a == req_operand_b;
         fpa_pkg::OP_NE: sa_in.cmp = req_operand_a != req_operand_b;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_ff.valid <= 1'b0;
      end else if (advance) begin
         sa_ff.valid <= sa_in.valid;
      end
      if (advance) begin
         sa_ff.opcode <= sa_in.opcode;
         sa_ff.neg    <= sa_in.neg;
         sa_ff.result <= sa_in.result;
         sa_ff.cmp    <= sa_in.cmp;
         sa_ff.status <= sa_in.status;
         mag_a_ff     <= mag_a_in;
         mag_b_ff     <= mag_b_in;
      end
   end

   // ---------------- Multiplier stage ----------------
   fpa_pkg::side_type             sb_ff;
   logic [WB-1:0]                 mag_a_b_ff, mag_b_b_ff;
   logic [fpa_pkg::PROD_BITS-1:0] product;

   fpa_mul u_mul (
      .clock   (clock),
      .enable  (advance),
      .mag_a   (mag_a_ff),
      .mag_b   (mag_b_ff),
      .product (product)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sb_ff.valid <= 1'b0;
      end else if (advance) begin
         sb_ff.valid <= sa_ff.valid;
      end
      if (advance) begin
         sb_ff.opcode <= sa_ff.opcode;
         sb_ff.neg    <= sa_ff.neg;
         sb_ff.result <= sa_ff.result;
         sb_ff.cmp    <= sa_ff.cmp;
         sb_ff.status <= sa_ff.status;
         mag_a_b_ff   <= mag_a_ff;
         mag_b_b_ff   <= mag_b_ff;
      end
   end

   // ---------------- Product rounding stage ----------------
   // The product is rounded half away from zero on its magnitude, then scaled
   // down by the fraction bits and saturated. The divider is loaded here too.
   fpa_pkg::side_type             sc_ff, sc_in;
   fpa_pkg::div_type              dc_ff, dc_in;
   logic [fpa_pkg::PROD_BITS:0]   rounded;
   logic [fpa_pkg::PROD_BITS:0]   scaled;
   fpa_pkg::sat_type              mul_sat;

   always_comb begin
      rounded = {1'b0, product} + fpa_pkg::ROUND_HALF;
      scaled  = rounded >> fpa_pkg::FRAC_BITS;
      mul_sat = fpa_pkg::sat_finish(sb_ff.neg, scaled[fpa_pkg::PROD_BITS-1:0]);
      sc_in   = sb_ff;
      if (sb_ff.opcode == fpa_pkg::OP_MUL) begin
         sc_in.result = mul_sat.value;
         sc_in.status = mul_sat.ovf ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
      end
      dc_in.rem = '0;
      dc_in.num = QB'(mag_a_b_ff) << fpa_pkg::FRAC_BITS;
      dc_in.den = mag_b_b_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_ff.valid <= 1'b0;
      end else if (advance) begin
         sc_ff.valid <= sc_in.valid;
      end
      if (advance) begin
         sc_ff.opcode <= sc_in.opcode;
         sc_ff.neg    <= sc_in.neg;
         sc_ff.result <= sc_in.result;
         sc_ff.cmp    <= sc_in.cmp;
         sc_ff.status <= sc_in.status;
         dc_ff        <= dc_in;
      end
   end

   // ---------------- Divider stages ----------------
   // Each stage shifts in one numerator bit and develops one quotient bit.
   fpa_pkg::side_type side_chain [0:QB];
   fpa_pkg::div_type  div_chain  [0:QB];

   assign side_chain[0] = sc_ff;
   assign div_chain[0]  = dc_ff;

   for (genvar g = 0; g < QB; g++) begin : g_div
      fpa_div_stage u_stage (
         .clock  (clock),
         .reset  (reset),
         .enable (advance),
         .side_i (side_chain[g]),
         .div_i  (div_chain[g]),
         .side_o (side_chain[g+1]),
         .div_o  (div_chain[g+1])
      );
   end

   // ---------------- Output register ----------------
   logic [WB-1:0] out_result;

   fpa_out_stage u_out (
      .clock  (clock),
      .reset  (reset),
      .enable (advance),
      .side_i (side_chain[QB]),
      .div_i  (div_chain[QB]),
      .valid  (rsp_valid),
      .result (out_result),
      .cmp    (rsp_compare_true),
      .status (rsp_status)
   );

   assign rsp_result_value = out_result;

`ifndef SYNTH
   // A comparison outcome never comes with a nonzero status.
   a_cmp_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_compare_true |-> rsp_status == fpa_pkg::ST_OK)
      else $error("compare flag with nonzero status");

   // An overflow word always carries one of the two saturation bounds.
   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == fpa_pkg::ST_OVF |->
         (rsp_result_value == fpa_pkg::SAT_MAX || rsp_result_value == fpa_pkg::SAT_MIN))
      else $error("overflow without saturated value");

   // A divide by zero returns a zero value.
   a_divz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == fpa_pkg::ST_DIVZ |-> rsp_result_value == '0)
      else $error("divide by zero with nonzero value");

   // A held output word keeps the whole pipeline frozen, so it stays valid.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("held output word changed");
`endif

endmodule
